@@ rtl/i2c_mra_pkg.sv @@
// Shared types and constants for the I2C register access master.
`timescale 1ns / 1ps

package i2c_mra_pkg;

  // Write buffer depth and derived widths
  localparam int unsigned MAX_BURST = 16;
  localparam int unsigned BUF_AW    = $clog2(MAX_BURST);
  localparam int unsigned CNT_W     = $clog2(MAX_BURST + 1);

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  // Reset value of the phase length register
  localparam logic [15:0] PHASE_TICKS_RST = 16'd10;

  // Input word
  typedef struct packed {
    logic [1:0] req_type;
    logic       sda_in;
    logic       is_read;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] data_byte;
    logic [4:0] burst_length;
  } req_t;

  // Result word
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       accepted;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       done_res;
  } rsp_t;

endpackage

@@ rtl/i2c_master_register_access_unit.sv @@
// I2C master that runs register write and read transactions, one item per clock while not stalled.
`timescale 1ns / 1ps

// Usage: each input word carries a request. A tick request advances the bus
// sequencer by one microsecond tick and samples sda_in. A load request appends
// data_byte to the write buffer while idle. A start request latches device,
// register, direction and read length and begins the bus sequence. Every
// accepted word returns exactly one result word with the pin levels, status
// flags and any received byte.
// Output: a result is registered, or held in the skid register while a result waits.
// Throughput: one word per clock while in_stall_o is low; the sequencer,
// counters and buffer update with each accepted word. A two-entry output
// stage (result register plus skid register) lets a new word enter while a
// result waits, so in_stall_o rises only when both entries hold results.
// Reset: the bus sits idle with SCL high and SDA driven high, the phase length
// returns to 10 ticks, the buffer count clears; buffer contents are not reset.
// Stall: while out_stall_i holds a valid result, it stays in place and at most
// one more word is accepted before in_stall_o goes high.
// The APB port holds phase_ticks at byte address 0; 0 acts as 1.
module i2c_master_register_access_unit
  import i2c_mra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Sequencer state codes
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START_A  = 4'd1;
  localparam logic [3:0] S_PUT_DEVW = 4'd2;
  localparam logic [3:0] S_ACK_DEVW = 4'd3;
  localparam logic [3:0] S_PUT_REG  = 4'd4;
  localparam logic [3:0] S_ACK_REG  = 4'd5;
  localparam logic [3:0] S_PUT_DATA = 4'd6;
  localparam logic [3:0] S_ACK_DATA = 4'd7;
  localparam logic [3:0] S_START_B  = 4'd8;
  localparam logic [3:0] S_PUT_DEVR = 4'd9;
  localparam logic [3:0] S_ACK_DEVR = 4'd10;
  localparam logic [3:0] S_GET      = 4'd11;
  localparam logic [3:0] S_MACK     = 4'd12;
  localparam logic [3:0] S_STOP     = 4'd13;

  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_BURST);

  logic [15:0]      phase_ticks_q;
  logic [3:0]       state_q, state_d;
  logic [15:0]      pc_q, pc_d;
  logic [1:0]       step_q, step_d;
  logic [2:0]       bit_q, bit_d;
  logic [CNT_W-1:0] byte_q, byte_d;
  logic [7:0]       shift_q, shift_d;
  logic [CNT_W-1:0] wcnt_q, wcnt_d;
  logic [6:0]       dev_q, dev_d;
  logic [7:0]       reg_q, reg_d;
  logic             dir_q, dir_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic             scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
  logic [7:0]       wbuf_q [MAX_BURST];

  logic             in_acc;
  logic             busy;
  logic             do_go;
  logic             buf_we;
  logic [BUF_AW-1:0] rd_addr;
  logic [7:0]       rd_byte;
  logic [CNT_W-1:0] byte_inc;
  logic [CNT_W-1:0] len_in;
  logic [15:0]      eff_ticks;
  logic             last_cur, last_nxt;
  rsp_t             res;

  logic             out_valid_q, skid_valid_q;
  rsp_t             out_q, skid_q;

  // APB register access
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, phase_ticks_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      phase_ticks_q <= pwdata[15:0];
    end
  end

  // Handshake
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign busy       = (state_q != S_IDLE);

  // Buffer read port and helpers
  assign byte_inc  = byte_q + CNT_W'(1);
  assign rd_addr   = (state_q == S_ACK_REG) ? BUF_AW'(0) : byte_inc[BUF_AW-1:0];
  assign rd_byte   = wbuf_q[rd_addr];
  assign eff_ticks = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;
  assign last_cur  = ({1'b0, byte_q} + {{CNT_W{1'b0}}, 1'b1}) >= {1'b0, len_q};
  assign len_in    = (in_data_i.burst_length == 5'd0) ? CNT_W'(1) :
                     ({{CNT_W{1'b0}}, in_data_i.burst_length} > {{5{1'b0}}, MAX_LEN}) ?
                     MAX_LEN : CNT_W'(in_data_i.burst_length);

  // Next state for one word
  always_comb begin
    state_d = state_q;  pc_d = pc_q;       step_d = step_q;
    bit_d   = bit_q;    byte_d = byte_q;   shift_d = shift_q;
    wcnt_d  = wcnt_q;   dev_d = dev_q;     reg_d = reg_q;
    dir_d   = dir_q;    len_d = len_q;
    scl_d   = scl_q;    sda_d = sda_q;     drv_d = drv_q;
    do_go   = 1'b0;     buf_we = 1'b0;
    res     = '0;

    case (in_data_i.req_type)
      REQ_TICK: begin
        if (busy) begin
          if ({1'b0, pc_q} + 17'd1 >= {1'b0, eff_ticks}) begin
            // end of the current phase
            pc_d  = 16'd0;
            do_go = 1'b1;
            case (state_q)
              S_START_A, S_START_B: begin
                if (step_q < 2'd2) begin
                  step_d = step_q + 2'd1;
                end else begin
                  state_d = (state_q == S_START_A) ? S_PUT_DEVW : S_PUT_DEVR;
                  step_d  = 2'd0;
                  bit_d   = 3'd0;
                  shift_d = {dev_q, (state_q == S_START_B)};
                end
              end
              S_PUT_DEVW, S_PUT_REG, S_PUT_DATA, S_PUT_DEVR: begin
                if (step_q == 2'd3) begin
                  state_d = state_q + 4'd1;
                  step_d  = 2'd0;
                end else if (step_q == 2'd2) begin
                  if (bit_q < 3'd7) begin
                    bit_d  = bit_q + 3'd1;
                    step_d = 2'd0;
                  end else begin
                    step_d = 2'd3;
                  end
                end else begin
                  step_d = step_q + 2'd1;
                end
              end
              S_ACK_DEVW, S_ACK_REG, S_ACK_DATA, S_ACK_DEVR: begin
                step_d = 2'd0;
                if (step_q == 2'd0) begin
                  step_d = 2'd1;
                end else if (state_q == S_ACK_DEVW) begin
                  state_d = S_PUT_REG;
                  bit_d   = 3'd0;
                  shift_d = reg_q;
                end else if (state_q == S_ACK_REG) begin
                  if (dir_q) begin
                    state_d = S_START_B;
                  end else if (wcnt_q != '0) begin
                    byte_d  = '0;
                    state_d = S_PUT_DATA;
                    bit_d   = 3'd0;
                    shift_d = rd_byte;
                  end else begin
                    state_d = S_STOP;
                  end
                end else if (state_q == S_ACK_DATA) begin
                  byte_d = byte_inc;
                  if (byte_inc < wcnt_q && byte_inc < MAX_LEN) begin
                    state_d = S_PUT_DATA;
                    bit_d   = 3'd0;
                    shift_d = rd_byte;
                  end else begin
                    state_d = S_STOP;
                  end
                end else begin
                  byte_d  = '0;
                  shift_d = 8'd0;
                  bit_d   = 3'd0;
                  state_d = S_GET;
                end
              end
              S_GET: begin
                if (step_q == 2'd0) begin
                  if (in_data_i.sda_in) shift_d[3'd7 - bit_q] = 1'b1;
                  step_d = 2'd1;
                end else if (bit_q < 3'd7) begin
                  bit_d  = bit_q + 3'd1;
                  step_d = 2'd0;
                end else begin
                  res.read_valid = 1'b1;
                  res.read_data  = shift_q;
                  res.read_last  = last_cur;
                  state_d = S_MACK;
                  step_d  = 2'd0;
                end
              end
              S_MACK: begin
                if (step_q < (last_cur ? 2'd2 : 2'd3)) begin
                  step_d = step_q + 2'd1;
                end else if (last_cur) begin
                  state_d = S_STOP;
                  step_d  = 2'd0;
                end else begin
                  byte_d  = byte_inc;
                  shift_d = 8'd0;
                  bit_d   = 3'd0;
                  state_d = S_GET;
                  step_d  = 2'd0;
                end
              end
              S_STOP: begin
                if (step_q < 2'd2) begin
                  step_d = step_q + 2'd1;
                end else begin
                  // finish: idle without touching the pins
                  do_go   = 1'b0;
                  state_d = S_IDLE;
                  step_d  = 2'd0;
                  wcnt_d  = '0;
                  res.done_res = 1'b1;
                end
              end
              default: do_go = 1'b0;
            endcase
          end else begin
            pc_d = pc_q + 16'd1;
          end
        end
      end
      REQ_LOAD: begin
        if (!busy && wcnt_q < MAX_LEN) begin
          buf_we       = 1'b1;
          wcnt_d       = wcnt_q + CNT_W'(1);
          res.accepted = 1'b1;
        end
      end
      REQ_START: begin
        if (!busy) begin
          dir_d   = in_data_i.is_read;
          dev_d   = in_data_i.dev_addr;
          reg_d   = in_data_i.reg_addr;
          len_d   = len_in;
          byte_d  = '0;
          bit_d   = 3'd0;
          shift_d = 8'd0;
          state_d = S_START_A;
          step_d  = 2'd0;
          pc_d    = 16'd0;
          do_go   = 1'b1;
          res.accepted = 1'b1;
        end
      end
      default: ;
    endcase

    // Apply the pin levels of the phase just entered
    last_nxt = ({1'b0, byte_d} + {{CNT_W{1'b0}}, 1'b1}) >= {1'b0, len_d};
    if (do_go) begin
      case (state_d)
        S_START_A, S_START_B: begin
          if (step_d == 2'd0)      scl_d = 1'b1;
          else if (step_d == 2'd1) sda_d = 1'b0;
          else                     scl_d = 1'b0;
        end
        S_PUT_DEVW, S_PUT_REG, S_PUT_DATA, S_PUT_DEVR: begin
          if (step_d == 2'd0)      sda_d = shift_d[3'd7 - bit_d];
          else if (step_d == 2'd1) scl_d = 1'b1;
          else if (step_d == 2'd2) scl_d = 1'b0;
          else                     sda_d = 1'b0;
        end
        S_ACK_DEVW, S_ACK_REG, S_ACK_DATA, S_ACK_DEVR: begin
          if (step_d == 2'd0) begin
            sda_d = 1'b1;
            drv_d = 1'b0;
            scl_d = 1'b1;
          end else begin
            drv_d = 1'b1;
            scl_d = 1'b0;
          end
        end
        S_GET: begin
          if (step_d == 2'd0) begin
            if (bit_d == 3'd0) begin
              sda_d = 1'b1;
              drv_d = 1'b0;
            end
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
        S_MACK: begin
          drv_d = 1'b1;
          if (step_d == 2'd0)      sda_d = last_nxt;
          else if (step_d == 2'd1) scl_d = 1'b1;
          else if (step_d == 2'd2) scl_d = 1'b0;
          else                     sda_d = 1'b1;
        end
        S_STOP: begin
          if (step_d == 2'd0)      sda_d = 1'b0;
          else if (step_d == 2'd1) scl_d = 1'b1;
          else                     sda_d = 1'b1;
        end
        default: ;
      endcase
    end

    res.scl_out   = scl_d;
    res.sda_out   = sda_d;
    res.sda_drive = drv_d;
    res.busy_res  = (state_d != S_IDLE);
  end

  // Sequencer and latched command registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= 16'd0;
      step_q  <= 2'd0;
      bit_q   <= 3'd0;
      byte_q  <= '0;
      shift_q <= 8'd0;
      wcnt_q  <= '0;
      dev_q   <= 7'd0;
      reg_q   <= 8'd0;
      dir_q   <= 1'b0;
      len_q   <= CNT_W'(1);
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b1;
    end else if (in_acc) begin
      state_q <= state_d;
      pc_q    <= pc_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      wcnt_q  <= wcnt_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      dir_q   <= dir_d;
      len_q   <= len_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drv_q   <= drv_d;
    end
  end

  // Write buffer
  always_ff @(posedge clk_i) begin
    if (in_acc && buf_we) begin
      wbuf_q[wcnt_q[BUF_AW-1:0]] <= in_data_i.data_byte;
    end
  end

  // Output register and skid entry: valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q  <= skid_valid_q || in_acc;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output register and skid entry: words
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // The skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without output word");

  // A start taken while idle leaves the sequencer running
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !busy && in_data_i.req_type == REQ_START) |=> (state_q == S_START_A))
    else $error("start command did not launch the sequence");

  // Buffer count never exceeds its depth
  a_wcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= MAX_LEN)
    else $error("write count beyond buffer depth");

  // A finished transaction reports idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res) |-> !out_q.busy_res)
    else $error("done reported while still busy");
`endif

endmodule

@@ bench/tb_i2c_master_register_access_unit.sv @@
// Self-checking bench for the I2C register access master against a cycle-free bus predictor.
`timescale 1ns / 1ps

module tb_i2c_master_register_access_unit;
  import i2c_mra_pkg::*;

  localparam logic [1:0] REQ_NONE         = 2'd3;
  localparam logic [2:0] ADDR_PHASE_TICKS = 3'd0;
  localparam int         CYCLE_LIMIT      = 600000;
  localparam int         RANDOM_WORDS     = 1200;
  localparam int         MAX_REPORTS      = 10;
  localparam int         SETTLE_CYCLES    = 20;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_START_A, SQ_PUT_DEVW, SQ_ACK_DEVW, SQ_PUT_REG, SQ_ACK_REG, SQ_PUT_DATA,
    SQ_ACK_DATA, SQ_START_B, SQ_PUT_DEVR, SQ_ACK_DEVR, SQ_GET, SQ_MACK, SQ_STOP
  } bus_seq_e;

  typedef enum logic [1:0] {ST_WORD, ST_CFG_WRITE, ST_CFG_READ, ST_DRAIN} stim_kind_e;

  typedef struct packed {
    stim_kind_e  kind;
    req_t        word;
    logic [15:0] value;
  } stim_t;

  typedef enum logic [1:0] {APB_OFF, APB_SETUP, APB_ACCESS} apb_phase_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  req_t        in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rsp_t        out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_register_access_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Predicted bus sequencer state
  logic [15:0] ticks_per_phase = PHASE_TICKS_RST;
  bus_seq_e    seq             = SQ_IDLE;
  logic [15:0] phase_cnt       = '0;
  logic [1:0]  phase_step      = '0;
  logic [2:0]  bit_idx         = '0;
  logic [4:0]  byte_idx        = '0;
  logic [7:0]  shift_reg       = '0;
  logic [7:0]  wbuf [MAX_BURST];
  logic [4:0]  wcount          = '0;
  logic [6:0]  dev_lat         = '0;
  logic [7:0]  reg_lat         = '0;
  logic        dir_lat         = 1'b0;
  logic [4:0]  len_lat         = 5'd1;
  logic        scl_lvl         = 1'b1;
  logic        sda_lvl         = 1'b1;
  logic        drv_lvl         = 1'b1;

  // Bench bookkeeping
  stim_t      stim_q[$];
  rsp_t       pending_rsp_q[$];
  apb_phase_e apb_phase   = APB_OFF;
  logic       word_taken  = 1'b0;
  logic       rsp_taken   = 1'b0;
  logic       apb_done    = 1'b0;
  logic       gaps_on     = 1'b1;
  logic       stalls_on   = 1'b1;
  int         gap_left    = 0;
  int         stall_left  = 0;
  int         gen_eff     = 10;
  int         n_planned   = 0;
  int         n_words     = 0;
  int         n_checked   = 0;
  int         n_starts    = 0;
  int         n_bytes_rd  = 0;
  int         n_reg_acc   = 0;
  int         errors      = 0;
  int         cycle_count = 0;

  function automatic logic on_last_byte();
    return (int'(byte_idx) + 1 >= int'(len_lat));
  endfunction

  // Apply the pin levels that belong to the phase just entered
  function automatic void set_phase_pins();
    case (seq)
      SQ_START_A, SQ_START_B: begin
        if (phase_step == 2'd0) scl_lvl = 1'b1;
        else if (phase_step == 2'd1) sda_lvl = 1'b0;
        else scl_lvl = 1'b0;
      end
      SQ_PUT_DEVW, SQ_PUT_REG, SQ_PUT_DATA, SQ_PUT_DEVR: begin
        if (phase_step == 2'd0) sda_lvl = shift_reg[3'd7 - bit_idx];
        else if (phase_step == 2'd1) scl_lvl = 1'b1;
        else if (phase_step == 2'd2) scl_lvl = 1'b0;
        else sda_lvl = 1'b0;
      end
      SQ_ACK_DEVW, SQ_ACK_REG, SQ_ACK_DATA, SQ_ACK_DEVR: begin
        if (phase_step == 2'd0) begin
          sda_lvl = 1'b1;
          drv_lvl = 1'b0;
          scl_lvl = 1'b1;
        end else begin
          drv_lvl = 1'b1;
          scl_lvl = 1'b0;
        end
      end
      SQ_GET: begin
        if (phase_step == 2'd0) begin
          if (bit_idx == 3'd0) begin
            sda_lvl = 1'b1;
            drv_lvl = 1'b0;
          end
          scl_lvl = 1'b1;
        end else begin
          scl_lvl = 1'b0;
        end
      end
      SQ_MACK: begin
        drv_lvl = 1'b1;
        if (phase_step == 2'd0) sda_lvl = on_last_byte();
        else if (phase_step == 2'd1) scl_lvl = 1'b1;
        else if (phase_step == 2'd2) scl_lvl = 1'b0;
        else sda_lvl = 1'b1;
      end
      SQ_STOP: begin
        if (phase_step == 2'd0) sda_lvl = 1'b0;
        else if (phase_step == 2'd1) scl_lvl = 1'b1;
        else sda_lvl = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void enter_phase(bus_seq_e st, logic [1:0] step);
    seq        = st;
    phase_step = step;
    phase_cnt  = '0;
    set_phase_pins();
  endfunction

  function automatic void load_shift(bus_seq_e st, logic [7:0] b);
    shift_reg = b;
    bit_idx   = '0;
    enter_phase(st, 2'd0);
  endfunction

  // Close the running phase and pick the next one; raise read and done flags
  function automatic rsp_t finish_phase(logic sda, rsp_t r);
    case (seq)
      SQ_START_A, SQ_START_B: begin
        if (phase_step < 2'd2) enter_phase(seq, phase_step + 2'd1);
        else if (seq == SQ_START_A) load_shift(SQ_PUT_DEVW, {dev_lat, 1'b0});
        else load_shift(SQ_PUT_DEVR, {dev_lat, 1'b1});
      end
      SQ_PUT_DEVW, SQ_PUT_REG, SQ_PUT_DATA, SQ_PUT_DEVR: begin
        if (phase_step == 2'd3) begin
          enter_phase(bus_seq_e'(seq + 1), 2'd0);
        end else if (phase_step == 2'd2) begin
          if (bit_idx < 3'd7) begin
            bit_idx = bit_idx + 3'd1;
            enter_phase(seq, 2'd0);
          end else begin
            enter_phase(seq, 2'd3);
          end
        end else begin
          enter_phase(seq, phase_step + 2'd1);
        end
      end
      SQ_ACK_DEVW, SQ_ACK_REG, SQ_ACK_DATA, SQ_ACK_DEVR: begin
        if (phase_step == 2'd0) begin
          enter_phase(seq, 2'd1);
        end else if (seq == SQ_ACK_DEVW) begin
          load_shift(SQ_PUT_REG, reg_lat);
        end else if (seq == SQ_ACK_REG) begin
          if (dir_lat) begin
            enter_phase(SQ_START_B, 2'd0);
          end else if (wcount > 5'd0) begin
            byte_idx = '0;
            load_shift(SQ_PUT_DATA, wbuf[0]);
          end else begin
            enter_phase(SQ_STOP, 2'd0);
          end
        end else if (seq == SQ_ACK_DATA) begin
          byte_idx = byte_idx + 5'd1;
          if (byte_idx < wcount && byte_idx < MAX_BURST) load_shift(SQ_PUT_DATA, wbuf[byte_idx[3:0]]);
          else enter_phase(SQ_STOP, 2'd0);
        end else begin
          byte_idx  = '0;
          shift_reg = '0;
          bit_idx   = '0;
          enter_phase(SQ_GET, 2'd0);
        end
      end
      SQ_GET: begin
        if (phase_step == 2'd0) begin
          if (sda) shift_reg[3'd7 - bit_idx] = 1'b1;
          enter_phase(SQ_GET, 2'd1);
        end else if (bit_idx < 3'd7) begin
          bit_idx = bit_idx + 3'd1;
          enter_phase(SQ_GET, 2'd0);
        end else begin
          r.read_valid = 1'b1;
          r.read_data  = shift_reg;
          r.read_last  = on_last_byte();
          n_bytes_rd++;
          enter_phase(SQ_MACK, 2'd0);
        end
      end
      SQ_MACK: begin
        if (phase_step < (on_last_byte() ? 2'd2 : 2'd3)) begin
          enter_phase(SQ_MACK, phase_step + 2'd1);
        end else if (on_last_byte()) begin
          enter_phase(SQ_STOP, 2'd0);
        end else begin
          byte_idx  = byte_idx + 5'd1;
          shift_reg = '0;
          bit_idx   = '0;
          enter_phase(SQ_GET, 2'd0);
        end
      end
      SQ_STOP: begin
        if (phase_step < 2'd2) begin
          enter_phase(SQ_STOP, phase_step + 2'd1);
        end else begin
          seq        = SQ_IDLE;
          phase_step = '0;
          phase_cnt  = '0;
          wcount     = '0;
          r.done_res = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Advance the predicted block by one input word and return its result word
  function automatic rsp_t predict_bus_response(req_t w);
    rsp_t       r;
    int         lim;
    logic [4:0] len;
    r = '0;
    case (w.req_type)
      REQ_TICK: begin
        if (seq != SQ_IDLE) begin
          lim = (ticks_per_phase == 16'd0) ? 1 : int'(ticks_per_phase);
          if (int'(phase_cnt) + 1 >= lim) r = finish_phase(w.sda_in, r);
          else phase_cnt = phase_cnt + 16'd1;
        end
      end
      REQ_LOAD: begin
        if (seq == SQ_IDLE && wcount < MAX_BURST) begin
          wbuf[wcount[3:0]] = w.data_byte;
          wcount     = wcount + 5'd1;
          r.accepted = 1'b1;
        end
      end
      REQ_START: begin
        if (seq == SQ_IDLE) begin
          len = w.burst_length;
          if (len == 5'd0) len = 5'd1;
          else if (len > MAX_BURST) len = 5'(MAX_BURST);
          dir_lat    = w.is_read;
          dev_lat    = w.dev_addr;
          reg_lat    = w.reg_addr;
          len_lat    = len;
          byte_idx   = '0;
          bit_idx    = '0;
          shift_reg  = '0;
          enter_phase(SQ_START_A, 2'd0);
          r.accepted = 1'b1;
          n_starts++;
        end
      end
      default: ;
    endcase
    r.scl_out   = scl_lvl;
    r.sda_out   = sda_lvl;
    r.sda_drive = drv_lvl;
    r.busy_res  = (seq != SQ_IDLE);
    return r;
  endfunction

  task automatic note_failure(string what, logic [15:0] want, logic [15:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("[%0t] %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) note_failure(what, {8'h00, want}, {8'h00, got});
  endtask

  task automatic compare_rsp(rsp_t want, rsp_t got);
    check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
    check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
    check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
    check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
    check_field("accepted", 8'(want.accepted), 8'(got.accepted));
    check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
    check_field("read_data", want.read_data, got.read_data);
    check_field("read_last", 8'(want.read_last), 8'(got.read_last));
    check_field("done_res", 8'(want.done_res), 8'(got.done_res));
  endtask

  // Sample handshakes, predict accepted words and check result words
  always @(posedge clk_i) begin
    rsp_t want;
    cycle_count++;
    word_taken = in_valid_i && !in_stall_o;
    rsp_taken  = out_valid_o && !out_stall_i;
    apb_done   = psel && penable && pready;
    if (rst_ni) begin
      if (word_taken) begin
        pending_rsp_q.push_back(predict_bus_response(in_data_i));
        n_words++;
      end
      if (rsp_taken) begin
        if (pending_rsp_q.size() == 0) begin
          note_failure("result word with none pending", '0, out_data_o);
        end else begin
          want = pending_rsp_q.pop_front();
          compare_rsp(want, out_data_o);
          n_checked++;
        end
      end
      if (apb_done) begin
        n_reg_acc++;
        if (pwrite) ticks_per_phase = pwdata[15:0];
        else if (prdata[15:0] !== ticks_per_phase)
          note_failure("phase_ticks readback", ticks_per_phase, prdata[15:0]);
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_rsp_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // Feed words and register accesses from the stimulus queue
  always @(negedge clk_i) begin : feed_words
    logic nv;
    if (rst_ni) begin
      nv = in_valid_i && !word_taken;
      if (apb_phase == APB_SETUP) begin
        penable <= 1'b1;
        apb_phase = APB_ACCESS;
      end else if (apb_phase == APB_ACCESS) begin
        if (apb_done) begin
          psel    <= 1'b0;
          penable <= 1'b0;
          pwrite  <= 1'b0;
          apb_phase = APB_OFF;
        end
      end else if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          case (stim_q[0].kind)
            ST_WORD: begin
              in_data_i <= stim_q[0].word;
              nv = 1'b1;
              if ($urandom_range(0, 63) == 0) gaps_on = !gaps_on;
              gap_left = gaps_on ? $urandom_range(0, 11) : 0;
              stim_q.delete(0);
            end
            ST_DRAIN: begin
              if (pending_rsp_q.size() == 0) stim_q.delete(0);
            end
            default: begin
              // registers change only with no result outstanding
              if (pending_rsp_q.size() == 0) begin
                psel    <= 1'b1;
                penable <= 1'b0;
                pwrite  <= (stim_q[0].kind == ST_CFG_WRITE);
                paddr   <= ADDR_PHASE_TICKS;
                pwdata  <= {16'h0000, stim_q[0].value};
                apb_phase = APB_SETUP;
                stim_q.delete(0);
              end
            end
          endcase
        end
      end
      in_valid_i <= nv;
    end
  end

  // Stall the result side at random after each taken result word
  always @(negedge clk_i) begin : hold_results
    if (rst_ni) begin
      if (rsp_taken) begin
        if ($urandom_range(0, 47) == 0) stalls_on = !stalls_on;
        stall_left = stalls_on ? $urandom_range(0, 11) : 0;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic req_t rand_word(logic [1:0] kind);
    req_t w;
    w = req_t'($urandom);
    w.req_type = kind;
    return w;
  endfunction

  function automatic logic [1:0] noise_kind();
    case ($urandom_range(0, 2))
      0:       return REQ_LOAD;
      1:       return REQ_START;
      default: return REQ_NONE;
    endcase
  endfunction

  task automatic push_word(req_t w);
    stim_q.push_back('{kind: ST_WORD, word: w, value: '0});
    n_planned++;
  endtask

  task automatic push_drain();
    stim_q.push_back('{kind: ST_DRAIN, word: '0, value: '0});
  endtask

  task automatic push_cfg(logic [15:0] v);
    stim_q.push_back('{kind: ST_CFG_WRITE, word: '0, value: v});
    stim_q.push_back('{kind: ST_CFG_READ, word: '0, value: '0});
    gen_eff = (v == 16'd0) ? 1 : int'(v);
  endtask

  // Push ticks; noisy runs sprinkle refused commands over the first half
  task automatic push_ticks(int n, logic noisy);
    for (int i = 0; i < n; i++) begin
      if (noisy && i < n / 2 && $urandom_range(0, 15) == 0) push_word(rand_word(noise_kind()));
      push_word(rand_word(REQ_TICK));
    end
  endtask

  // Load bytes, start, then tick for keep_pct percent of what the whole transaction needs
  task automatic push_transaction(logic dir, logic [6:0] dev, logic [7:0] reg_a,
                                  logic [4:0] len, int nloads, int prior, int keep_pct);
    req_t w;
    int   loaded;
    int   reads;
    int   phases;
    for (int i = 0; i < nloads; i++) push_word(rand_word(REQ_LOAD));
    w              = rand_word(REQ_START);
    w.is_read      = dir;
    w.dev_addr     = dev;
    w.reg_addr     = reg_a;
    w.burst_length = len;
    push_word(w);
    loaded = (nloads + prior > int'(MAX_BURST)) ? int'(MAX_BURST) : nloads + prior;
    reads  = (len == 5'd0) ? 1 : (len > MAX_BURST) ? int'(MAX_BURST) : int'(len);
    phases = dir ? 89 + 20 * reads : 60 + 27 * loaded;
    push_ticks(phases * gen_eff * keep_pct / 100 + $urandom_range(0, 4), 1'b1);
  endtask

  task automatic build_directed();
    req_t w;
    // idle reports right after reset
    push_word(rand_word(REQ_NONE));
    push_word(rand_word(REQ_TICK));
    // extreme bytes and addresses at the reset phase length
    w = rand_word(REQ_LOAD);
    w.data_byte = 8'h00;
    push_word(w);
    w.data_byte = 8'hFF;
    push_word(w);
    w              = rand_word(REQ_START);
    w.is_read      = 1'b0;
    w.dev_addr     = 7'h7F;
    w.reg_addr     = 8'hFF;
    w.burst_length = 5'h1F;
    push_word(w);
    push_ticks(37, 1'b0);
    // commands while busy are refused
    push_word(rand_word(REQ_START));
    push_word(rand_word(REQ_LOAD));
    // shrink the phase length under a phase already past it
    push_cfg(16'd1);
    push_ticks(60 + 2 * 27 + 4, 1'b0);
    push_drain();
    // zero read length reads one byte
    push_transaction(1'b1, 7'h00, 8'h00, 5'd0, 0, 0, 100);
    // zero phase length acts as one; oversized read length clamps
    push_cfg(16'd0);
    push_transaction(1'b1, 7'h7F, 8'hFF, 5'd17, 0, 0, 100);
    // overfilled buffer, then a write with nothing buffered
    push_transaction(1'b0, 7'($urandom), 8'($urandom), 5'($urandom), 17, 0, 100);
    push_transaction(1'b0, 7'($urandom), 8'($urandom), 5'($urandom), 0, 0, 100);
    // longest phase length, cut short mid-phase
    push_cfg(16'hFFFF);
    w         = rand_word(REQ_START);
    w.is_read = 1'b0;
    push_word(w);
    push_ticks(5, 1'b0);
    push_cfg(16'd2);
    push_ticks(60 * 2 + 4, 1'b0);
    push_drain();
  endtask

  task automatic build_random();
    int   goal;
    int   pick;
    int   nloads;
    logic dir;
    logic [4:0] len;
    goal = n_planned + RANDOM_WORDS;
    while (n_planned < goal) begin
      pick   = $urandom_range(0, 19);
      dir    = 1'($urandom);
      nloads = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 3);
      if (dir) len = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
      else len = 5'($urandom);
      if (pick == 0) begin
        push_cfg(16'($urandom_range(0, 2)));
      end else if (pick == 1) begin
        push_drain();
      end else if (pick <= 3) begin
        // idle noise: ticks, unknown requests and stray loads
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 2))
            0:       push_word(rand_word(REQ_TICK));
            1:       push_word(rand_word(REQ_LOAD));
            default: push_word(rand_word(REQ_NONE));
          endcase
        end
      end else if (pick == 4) begin
        // transaction whose ticks stop early
        push_transaction(dir, 7'($urandom), 8'($urandom), len, nloads, 0,
                         $urandom_range(10, 80));
      end else begin
        push_transaction(dir, 7'($urandom), 8'($urandom), len, nloads, 0, 100);
      end
    end
    push_cfg(PHASE_TICKS_RST);
  endtask

  initial begin
    build_directed();
    build_random();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    // drain everything, then watch for stray results
    while (stim_q.size() != 0 || in_valid_i || apb_phase != APB_OFF ||
           pending_rsp_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d result words for %0d input words over %0d cycles.",
             n_checked, n_words, cycle_count);
    $display("Bus: %0d transactions started, %0d bytes read, %0d register accesses.",
             n_starts, n_bytes_rd, n_reg_acc);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ i2c_master_register_access_unit.f @@
rtl/i2c_mra_pkg.sv
rtl/i2c_master_register_access_unit.sv
bench/tb_i2c_master_register_access_unit.sv
